@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain property checked at every clock edge outside reset
`define NECIRD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define NECIRD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define NECIRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NECIRD_ASSERT(lbl, clk, rst, prop, msg)
`define NECIRD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define NECIRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/necird_pkg.sv @@
// ----------------------------------------------------------------------------
// necird_pkg
// types, register map and interval helpers of the ir frame decoder
// ----------------------------------------------------------------------------
package necird_pkg;

   // field widths
   localparam int TIME_W     = 16;
   localparam int LIMIT_W    = 8;
   localparam int ADDR_W     = 16;
   localparam int CMD_W      = 8;
   localparam int FULL_W     = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [LIMIT_W-1:0] limit_type;

   // request kinds
   typedef enum logic [1:0] {
      REQ_EDGE = 2'd0,
      REQ_TICK = 2'd1,
      REQ_ARM  = 2'd2,
      REQ_STOP = 2'd3
   } req_kind_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BIT_ERR   = 2'd1,
      ST_CHECK_ERR = 2'd2,
      ST_TIMEOUT   = 2'd3
   } status_type;

   // decoder phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HEAD = 2'd1,
      PH_RECV = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   // register indexes
   localparam logic [2:0] CSR_HEAD_TIME   = 3'd0;
   localparam logic [2:0] CSR_HEAD_MARGIN = 3'd1;
   localparam logic [2:0] CSR_ZERO_TIME   = 3'd2;
   localparam logic [2:0] CSR_ONE_TIME    = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT     = 3'd4;

   // reset values
   localparam time_type  HEAD_TIME_RST   = 16'd13500;
   localparam time_type  HEAD_MARGIN_RST = 16'd3375;
   localparam time_type  ZERO_TIME_RST   = 16'd1125;
   localparam time_type  ONE_TIME_RST    = 16'd2250;
   localparam limit_type TIMEOUT_RST     = 8'd10;

   localparam logic [CMD_W-1:0] CHECK_XOR = 8'hFF;

   // configuration seen by the decoder
   typedef struct packed {
      time_type  head_time;
      time_type  head_margin;
      time_type  bit_zero_time;
      time_type  bit_one_time;
      limit_type timeout_limit;
   } cfg_type;

   // strictly inside nominal +/- nominal/4, no wrap
   function automatic logic in_window(time_type d, time_type nom);
      logic [TIME_W:0] q;
      logic [TIME_W:0] hi;
      logic [TIME_W:0] lo;
      q  = {3'b000, nom[TIME_W-1:2]};
      hi = {1'b0, nom} + q;
      lo = {1'b0, d} + q;
      return ({1'b0, d} < hi) && (lo > {1'b0, nom});
   endfunction

   // strictly inside head time +/- margin, no wrap
   function automatic logic head_hit(time_type d, time_type ht, time_type hm);
      logic [TIME_W:0] hi;
      logic [TIME_W:0] lo;
      hi = {1'b0, ht} + {1'b0, hm};
      lo = {1'b0, d} + {1'b0, hm};
      return ({1'b0, d} < hi) && (lo > {1'b0, ht});
   endfunction

endpackage

@@ design/necird_req_if.sv @@
// ----------------------------------------------------------------------------
// necird_req_if
// request channel: edge timestamps, ticks and arm/stop commands
// ----------------------------------------------------------------------------
interface necird_req_if import necird_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic [TIME_W-1:0]       edge_time;

   modport source (output valid, output req_type, output edge_time, input ready);
   modport sink   (input valid, input req_type, input edge_time, output ready);
endinterface

@@ design/necird_rsp_if.sv @@
// ----------------------------------------------------------------------------
// necird_rsp_if
// response channel: decoded frames and error status
// ----------------------------------------------------------------------------
interface necird_rsp_if import necird_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic [ADDR_W-1:0]       address;
   logic [CMD_W-1:0]        command;

   modport source (output valid, output status, output address, output command,
                   input ready);
   modport sink   (input valid, input status, input address, input command,
                   output ready);
endinterface

@@ design/necird_csr.sv @@
// ----------------------------------------------------------------------------
// necird_csr
// apb register bank holding the timing windows and timeout limit
// ----------------------------------------------------------------------------
module necird_csr import necird_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_HEAD_TIME:   cfg_in.head_time     = pwdata[TIME_W-1:0];
            CSR_HEAD_MARGIN: cfg_in.head_margin   = pwdata[TIME_W-1:0];
            CSR_ZERO_TIME:   cfg_in.bit_zero_time = pwdata[TIME_W-1:0];
            CSR_ONE_TIME:    cfg_in.bit_one_time  = pwdata[TIME_W-1:0];
            CSR_TIMEOUT:     cfg_in.timeout_limit = pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_time     <= HEAD_TIME_RST;
         cfg_ff.head_margin   <= HEAD_MARGIN_RST;
         cfg_ff.bit_zero_time <= ZERO_TIME_RST;
         cfg_ff.bit_one_time  <= ONE_TIME_RST;
         cfg_ff.timeout_limit <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         CSR_HEAD_TIME:   prdata = CSR_DATA_W'(cfg_ff.head_time);
         CSR_HEAD_MARGIN: prdata = CSR_DATA_W'(cfg_ff.head_margin);
         CSR_ZERO_TIME:   prdata = CSR_DATA_W'(cfg_ff.bit_zero_time);
         CSR_ONE_TIME:    prdata = CSR_DATA_W'(cfg_ff.bit_one_time);
         CSR_TIMEOUT:     prdata = CSR_DATA_W'(cfg_ff.timeout_limit);
         default:         prdata = '0;
      endcase
   end

endmodule

@@ design/necird_core.sv @@
// ----------------------------------------------------------------------------
// necird_core
// input register, frame state machine and response register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module necird_core import necird_pkg::*; #(
   parameter int FRAME_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   necird_req_if.sink     req_chan,
   necird_rsp_if.source   rsp_chan
);

   localparam int BIT_W = $clog2(FRAME_BITS);

   // input register
   logic         in_vld_ff, in_vld_in;
   req_kind_type in_kind_ff;
   time_type     in_time_ff;
   logic         accept;
   logic         fire;

   // decoder state
   phase_type            phase_ff, phase_in;
   time_type             last_ff, last_in;
   logic                 have_ff, have_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   limit_type            ticks_ff, ticks_in;

   // response register
   logic              out_vld_ff, out_vld_in;
   status_type        status_ff;
   logic [ADDR_W-1:0] address_ff;
   logic [CMD_W-1:0]  command_ff;

   // per-item working values
   logic                  emit;
   status_type            emit_status;
   logic [ADDR_W-1:0]     emit_addr;
   logic [CMD_W-1:0]      emit_cmd;
   logic                  clear;
   phase_type             clear_phase;
   time_type              interval;
   limit_type             ticks_inc;
   logic                  is_one;
   logic                  is_zero;
   logic [FRAME_BITS-1:0] frame_next;
   logic [FULL_W-1:0]     word;
   logic                  bit_last;

   // handshake: process when the response slot is free or draining
   assign fire           = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff <= req_kind_type'(req_chan.req_type);
         in_time_ff <= req_chan.edge_time;
      end
   end

   // interval classification
   assign interval   = in_time_ff - last_ff;
   assign ticks_inc  = (ticks_ff == '1) ? ticks_ff : ticks_ff + limit_type'(1);
   assign is_one     = in_window(interval, cfg.bit_one_time);
   assign is_zero    = in_window(interval, cfg.bit_zero_time);
   assign frame_next = is_one ? (frame_ff | (FRAME_BITS'(1) << bit_ff)) : frame_ff;
   assign word       = FULL_W'(frame_next);
   assign bit_last   = (bit_ff == BIT_W'(FRAME_BITS - 1));

   // next state and result
   always_comb begin
      phase_in    = phase_ff;
      last_in     = last_ff;
      have_in     = have_ff;
      bit_in      = bit_ff;
      frame_in    = frame_ff;
      ticks_in    = ticks_ff;
      emit        = 1'b0;
      emit_status = ST_OK;
      emit_addr   = '0;
      emit_cmd    = '0;
      clear       = 1'b0;
      clear_phase = PH_HEAD;
      if (fire) begin
         unique case (in_kind_ff)
            REQ_ARM: begin
               clear = 1'b1;
            end
            REQ_STOP: begin
               clear       = 1'b1;
               clear_phase = PH_IDLE;
            end
            REQ_TICK: begin
               // timeout only counts once a frame is under way or done
               if (phase_ff == PH_RECV || phase_ff == PH_DONE) begin
                  if (ticks_inc >= cfg.timeout_limit) begin
                     clear = 1'b1;
                     if (phase_ff == PH_RECV) begin
                        emit        = 1'b1;
                        emit_status = ST_TIMEOUT;
                     end
                  end else begin
                     ticks_in = ticks_inc;
                  end
               end
            end
            REQ_EDGE: begin
               ticks_in = '0;
               if (phase_ff != PH_IDLE) begin
                  if (!have_ff || phase_ff == PH_DONE) begin
                     // reference edge only
                     last_in = in_time_ff;
                     have_in = 1'b1;
                  end else begin
                     last_in = in_time_ff;
                     if (phase_ff == PH_HEAD) begin
                        if (head_hit(interval, cfg.head_time, cfg.head_margin)) begin
                           phase_in = PH_RECV;
                           bit_in   = '0;
                           frame_in = '0;
                        end
                     end else if (!is_one && !is_zero) begin
                        clear       = 1'b1;
                        emit        = 1'b1;
                        emit_status = ST_BIT_ERR;
                     end else if (!bit_last) begin
                        bit_in   = bit_ff + BIT_W'(1);
                        frame_in = frame_next;
                     end else if ((word[23:16] ^ word[31:24]) == CHECK_XOR) begin
                        // complete frame with good command check
                        phase_in  = PH_DONE;
                        bit_in    = '0;
                        frame_in  = '0;
                        emit      = 1'b1;
                        emit_addr = {word[7:0], word[15:8]};
                        emit_cmd  = word[23:16];
                     end else begin
                        clear       = 1'b1;
                        emit        = 1'b1;
                        emit_status = ST_CHECK_ERR;
                     end
                  end
               end
            end
         endcase
      end
      // drop the capture and go to the chosen phase
      if (clear) begin
         phase_in = clear_phase;
         have_in  = 1'b0;
         bit_in   = '0;
         frame_in = '0;
         ticks_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         last_ff  <= '0;
         have_ff  <= 1'b0;
         bit_ff   <= '0;
         frame_ff <= '0;
         ticks_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         last_ff  <= last_in;
         have_ff  <= have_in;
         bit_ff   <= bit_in;
         frame_ff <= frame_in;
         ticks_ff <= ticks_in;
      end
   end

   // response register
   always_comb begin
      out_vld_in = out_vld_ff;
      if (fire && emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         status_ff  <= emit_status;
         address_ff <= emit_addr;
         command_ff <= emit_cmd;
      end
   end

   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.status  = status_ff;
   assign rsp_chan.address = address_ff;
   assign rsp_chan.command = command_ff;

   // checks
   `NECIRD_ASSERT_IMPL(a_rsp_from_fire, clock, reset, $rose(out_vld_ff), $past(fire), "response without a processed transaction")
   `NECIRD_ASSERT_NEXT(a_ok_to_done, clock, reset, fire && emit && emit_status == ST_OK, phase_ff == PH_DONE, "decoded frame did not enter done phase")
   `NECIRD_ASSERT(a_bit_idx_idle, clock, reset, phase_ff == PH_RECV || bit_ff == '0, "bit index nonzero outside receive phase")
   `NECIRD_ASSERT_IMPL(a_err_payload, clock, reset, out_vld_ff && status_ff != ST_OK, address_ff == '0 && command_ff == '0, "error response carries frame data")

endmodule

@@ design/nec_ir_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// extended nec infrared frame decoder working on edge timestamps
// ----------------------------------------------------------------------------
// The req_chan channel carries one transaction per edge timestamp, timer tick,
// arm or stop command. The decoder is armed, waits for a header interval,
// then sorts the following intervals into ones and zeros and reports a
// decoded frame, a bit timing error, a failed command check or a timeout on
// rsp_chan. Most transactions give no response.
// Timing windows and the tick timeout are set through the apb port and may
// only be changed while no transaction is in flight.
// A response is written into the response register after its request has passed
// the input register and the classify logic.
// Throughput: one transaction per cycle; a stalled response holds only
// while rsp_chan.ready is low, and req_chan.ready drops once the input
// register is also full.
// Reset returns the registers to their defaults, the decoder to idle and
// empties both the input and response registers.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder import necird_pkg::*; #(
   parameter int FRAME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   necird_req_if.sink            req_chan,
   necird_rsp_if.source          rsp_chan
);

   cfg_type cfg;

   // register bank
   necird_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // decoder
   necird_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
